/* rtl/lti_pkg.sv */
// Shared types, codes and width helpers for the line/triangle intersect block.
package lti_pkg;

   // Result classification codes
   typedef enum logic [1:0] {
      STATUS_DEGENERATE = 2'd0,
      STATUS_PARALLEL   = 2'd1,
      STATUS_OUTSIDE    = 2'd2,
      STATUS_INSIDE     = 2'd3
   } status_type;

   // Register index of the tolerance register
   localparam logic CSR_IDX_EPSILON = 1'b0;

   // Quotient bits produced by the divider stages (the 2^31 cap is tested apart)
   localparam int Q_BITS = 31;

   // Saturation limits of the hit coordinates
   localparam logic [31:0] HIT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] HIT_MIN = 32'h8000_0000;

   // Bits of one classified request between front and back
   function automatic int item_width(input int w);
      return 2 + 3 * w + 3 * (w + 1) + 5 * (3 * w + 6);
   endfunction

endpackage

/* rtl/lti_queue.sv */
// Small register queue between the front and back pipelines.
module lti_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/lti_front.sv */
// Front pipeline: edge vectors, cross products, dot products and classification.
module lti_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_push,
   output logic        in_full,
   input  logic [47:0] seg_start,
   input  logic [47:0] seg_end,
   input  logic [47:0] vert0,
   input  logic [47:0] vert1,
   input  logic [47:0] vert2,
   input  logic [30:0] epsilon,
   input  logic        q_full,
   output logic        q_push,
   output logic [lti_pkg::item_width(COORD_WIDTH)-1:0] q_data
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int NW   = 2 * W + 3;
   localparam int LW   = W + 2;
   localparam int HW   = NW - LW;
   localparam int PW   = 3 * W + 6;
   localparam int QW   = 4 * W + 8;
   localparam int EXTW = (3 * W > 48) ? 3 * W : 48;
   localparam int CMPW = ((QW > 62) ? QW : 62) + 1;
   localparam int NDOT = 5;
   // dot product slots
   localparam int DOT_B   = 0;
   localparam int DOT_AN  = 1;
   localparam int DOT_DET = 2;
   localparam int DOT_SN  = 3;
   localparam int DOT_TN  = 4;

   // component c of a packed point, bits above 47 read as zero
   function automatic logic signed [W-1:0] comp(input logic [47:0] x, input int c);
      logic [EXTW-1:0] t;
      t = EXTW'(x);
      return t[c*W +: W];
   endfunction

   function automatic logic signed [NW-1:0] cross_c(input logic signed [DW-1:0] a [3],
                                                    input logic signed [DW-1:0] b [3],
                                                    input int c);
      logic signed [2*DW-1:0] p;
      logic signed [2*DW-1:0] q;
      int j;
      int k;
      j = (c == 2) ? 0 : c + 1;
      k = (j == 2) ? 0 : j + 1;
      p = a[j] * b[k];
      q = a[k] * b[j];
      return NW'(p) - NW'(q);
   endfunction

   function automatic logic signed [DW+HW-1:0] mul_hi(input logic signed [DW-1:0] x,
                                                      input logic signed [NW-1:0] y);
      logic signed [HW-1:0] h;
      h = y[NW-1:LW];
      return x * h;
   endfunction

   function automatic logic signed [DW+LW:0] mul_lo(input logic signed [DW-1:0] x,
                                                    input logic signed [NW-1:0] y);
      logic signed [LW:0] l;
      l = {1'b0, y[LW-1:0]};
      return x * l;
   endfunction

   logic [4:0] valid_ff;
   logic       en;
   logic [61:0] eps_sq_ff;

   logic signed [W-1:0]  pt_s [3];
   logic signed [W-1:0]  pt_e [3];
   logic signed [W-1:0]  pt_0 [3];
   logic signed [W-1:0]  pt_1 [3];
   logic signed [W-1:0]  pt_2 [3];

   // stage 1
   logic signed [W-1:0]  s1_ff [3];
   logic signed [DW-1:0] u1_ff [3], v1_ff [3], d1_ff [3], w1_ff [3];
   // stage 2
   logic signed [W-1:0]  s2_ff [3];
   logic signed [DW-1:0] u2_ff [3], d2_ff [3], w2_ff [3];
   logic signed [NW-1:0] n2_ff [3], pv2_ff [3], qu2_ff [3];
   // stage 3
   logic signed [W-1:0]      s3_ff [3];
   logic signed [DW-1:0]     d3_ff [3];
   logic signed [2*HW-1:0]   hh3_ff [3];
   logic signed [HW+LW:0]    hl3_ff [3];
   logic [2*LW-1:0]          ll3_ff [3];
   logic signed [DW+HW-1:0]  ph3_ff [NDOT][3];
   logic signed [DW+LW:0]    pl3_ff [NDOT][3];
   logic signed [DW-1:0]     dx [NDOT][3];
   logic signed [NW-1:0]     dy [NDOT][3];
   // stage 4
   logic signed [W-1:0]  s4_ff [3];
   logic signed [DW-1:0] d4_ff [3];
   logic [QW-1:0]        nn4_ff, nn4_in;
   logic signed [PW-1:0] dot4_ff [NDOT], dot4_in [NDOT];
   // stage 5
   lti_pkg::status_type  cls5_ff, cls5_in;
   logic signed [W-1:0]  s5_ff [3];
   logic signed [DW-1:0] d5_ff [3];
   logic signed [PW-1:0] a5_ff, b5_ff, det5_ff, sn5_ff, tn5_ff;
   logic [PW-1:0]        babs;
   logic                 deg, par;

   // pipeline advances unless the last stage holds a request the queue cannot take
   assign en      = !valid_ff[4] || !q_full;
   assign in_full = !en;
   assign q_push  = valid_ff[4] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_push};
      end
   end

   // squared tolerance, stable by the time any request reaches classification
   always_ff @(posedge clock) begin
      eps_sq_ff <= epsilon * epsilon;
   end

   // unpack coordinates
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pt_s[c] = comp(seg_start, c);
         pt_e[c] = comp(seg_end, c);
         pt_0[c] = comp(vert0, c);
         pt_1[c] = comp(vert1, c);
         pt_2[c] = comp(vert2, c);
      end
   end

   // operands of the five dot products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dx[DOT_B][c]   = d2_ff[c];  dy[DOT_B][c]   = n2_ff[c];
         dx[DOT_AN][c]  = w2_ff[c];  dy[DOT_AN][c]  = n2_ff[c];
         dx[DOT_DET][c] = u2_ff[c];  dy[DOT_DET][c] = pv2_ff[c];
         dx[DOT_SN][c]  = w2_ff[c];  dy[DOT_SN][c]  = pv2_ff[c];
         dx[DOT_TN][c]  = d2_ff[c];  dy[DOT_TN][c]  = qu2_ff[c];
      end
   end

   // sums of partial products
   always_comb begin
      nn4_in = '0;
      for (int c = 0; c < 3; c++) begin
         nn4_in = nn4_in + (QW'(hh3_ff[c]) <<< (2 * LW)) + (QW'(hl3_ff[c]) <<< (LW + 1))
                  + QW'(ll3_ff[c]);
      end
      for (int i = 0; i < NDOT; i++) begin
         dot4_in[i] = '0;
         for (int c = 0; c < 3; c++) begin
            dot4_in[i] = dot4_in[i] + (PW'(ph3_ff[i][c]) <<< LW) + PW'(pl3_ff[i][c]);
         end
      end
   end

   // degenerate and parallel tests
   always_comb begin
      babs = dot4_ff[DOT_B][PW-1] ? PW'(-dot4_ff[DOT_B]) : PW'(dot4_ff[DOT_B]);
      deg  = CMPW'(nn4_ff) < CMPW'(eps_sq_ff);
      par  = (dot4_ff[DOT_B] == '0) || (CMPW'(babs) < CMPW'(epsilon));
      if (deg) begin
         cls5_in = lti_pkg::STATUS_DEGENERATE;
      end else if (par) begin
         cls5_in = lti_pkg::STATUS_PARALLEL;
      end else begin
         cls5_in = lti_pkg::STATUS_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            // stage 1: edge and line vectors
            s1_ff[c] <= pt_s[c];
            u1_ff[c] <= DW'(pt_1[c]) - DW'(pt_0[c]);
            v1_ff[c] <= DW'(pt_2[c]) - DW'(pt_0[c]);
            d1_ff[c] <= DW'(pt_e[c]) - DW'(pt_s[c]);
            w1_ff[c] <= DW'(pt_s[c]) - DW'(pt_0[c]);
            // stage 2: normal and the two helper cross products
            s2_ff[c]  <= s1_ff[c];
            u2_ff[c]  <= u1_ff[c];
            d2_ff[c]  <= d1_ff[c];
            w2_ff[c]  <= w1_ff[c];
            n2_ff[c]  <= cross_c(u1_ff, v1_ff, c);
            pv2_ff[c] <= cross_c(d1_ff, v1_ff, c);
            qu2_ff[c] <= cross_c(w1_ff, u1_ff, c);
            // stage 3: split products
            s3_ff[c]  <= s2_ff[c];
            d3_ff[c]  <= d2_ff[c];
            hh3_ff[c] <= $signed(n2_ff[c][NW-1:LW]) * $signed(n2_ff[c][NW-1:LW]);
            hl3_ff[c] <= $signed(n2_ff[c][NW-1:LW]) * $signed({1'b0, n2_ff[c][LW-1:0]});
            ll3_ff[c] <= n2_ff[c][LW-1:0] * n2_ff[c][LW-1:0];
            for (int i = 0; i < NDOT; i++) begin
               ph3_ff[i][c] <= mul_hi(dx[i][c], dy[i][c]);
               pl3_ff[i][c] <= mul_lo(dx[i][c], dy[i][c]);
            end
            // stage 4: sums
            s4_ff[c] <= s3_ff[c];
            d4_ff[c] <= d3_ff[c];
            // stage 5: classified request
            s5_ff[c] <= s4_ff[c];
            d5_ff[c] <= d4_ff[c];
         end
         nn4_ff <= nn4_in;
         for (int i = 0; i < NDOT; i++) begin
            dot4_ff[i] <= dot4_in[i];
         end
         cls5_ff <= cls5_in;
         a5_ff   <= -dot4_ff[DOT_AN];
         b5_ff   <= dot4_ff[DOT_B];
         det5_ff <= dot4_ff[DOT_DET];
         sn5_ff  <= dot4_ff[DOT_SN];
         tn5_ff  <= dot4_ff[DOT_TN];
      end
   end

   assign q_data = {cls5_ff, s5_ff[2], s5_ff[1], s5_ff[0], d5_ff[2], d5_ff[1], d5_ff[0],
                    a5_ff, b5_ff, det5_ff, sn5_ff, tn5_ff};

endmodule

/* rtl/lti_back.sv */
// Back pipeline: hit point numerators, pipelined rounding divider, inside test.
module lti_back #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic [lti_pkg::item_width(COORD_WIDTH)-1:0] q_data,
   input  logic        out_pop,
   output logic        out_empty,
   output logic [1:0]  status,
   output logic [31:0] hit_x,
   output logic [31:0] hit_y,
   output logic [31:0] hit_z
);

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = W + 1;
   localparam int CKW  = W + 2;
   localparam int PW   = 3 * CKW;
   localparam int NUMW = 4 * W + 8;
   localparam int SBW  = W + CKW + 1;
   localparam int DAW  = DW + CKW + 1;
   localparam int IW   = PW + 2;
   localparam int DENW = PW + 1;
   localparam int N2W  = NUMW + F + 2;
   localparam int RW   = (N2W > DENW + 31) ? N2W : DENW + 31;
   localparam int QB   = lti_pkg::Q_BITS;

   // chunk k of a wide value, the top chunk signed
   function automatic logic signed [CKW:0] chunk(input logic signed [PW-1:0] x, input int k);
      logic signed [CKW:0] r;
      if (k == 2) begin
         r = {x[PW-1], x[2*CKW +: CKW]};
      end else begin
         r = {1'b0, x[k*CKW +: CKW]};
      end
      return r;
   endfunction

   logic                 en;
   logic [1:0]           cls_raw;
   logic signed [W-1:0]  mi_s [3];
   logic signed [DW-1:0] mi_d [3];
   logic signed [PW-1:0] mi_a, mi_b, mi_det, mi_sn, mi_tn;

   // stage 1
   logic                 b1_valid_ff;
   lti_pkg::status_type  b1_cls_ff;
   logic signed [SBW-1:0] b1_sb_ff [3][3];
   logic signed [DAW-1:0] b1_da_ff [3][3];
   logic signed [PW-1:0] b1_b_ff, b1_det_ff, b1_sn_ff, b1_tn_ff;
   // stage 2
   logic                 b2_valid_ff;
   lti_pkg::status_type  b2_cls_ff;
   logic signed [NUMW-1:0] b2_num_ff [3], num_in [3];
   logic                 b2_inside_ff, inside_in;
   logic [PW-1:0]        b2_babs_ff;
   logic                 b2_bneg_ff;
   logic signed [IW-1:0] det_x, sn_x, tn_x;
   // divider stages, index 0 is the setup stage
   logic [QB:0]          dv_valid_ff;
   lti_pkg::status_type  dv_cls_ff [QB+1];
   logic [QB:0]          dv_inside_ff;
   logic [DENW-1:0]      dv_den_ff [QB+1], dv_den_in [QB+1];
   logic [RW-1:0]        dv_rem_ff [QB+1][3], dv_rem_in [QB+1][3];
   logic [QB-1:0]        dv_q_ff [QB+1][3], dv_q_in [QB+1][3];
   logic                 dv_neg_ff [QB+1][3], dv_neg_in [QB+1][3];
   logic                 dv_cap_ff [QB+1][3], dv_cap_in [QB+1][3];
   logic [NUMW-1:0]      num_abs [3];
   logic [RW-1:0]        shifted;
   // output register
   logic                 out_valid_ff;
   lti_pkg::status_type  out_status_ff, out_status_in;
   logic [31:0]          out_hit_ff [3], out_hit_in [3];

   assign {cls_raw, mi_s[2], mi_s[1], mi_s[0], mi_d[2], mi_d[1], mi_d[0],
           mi_a, mi_b, mi_det, mi_sn, mi_tn} = q_data;

   // whole back pipeline moves unless a result waits and is not taken
   assign en        = !out_valid_ff || out_pop;
   assign q_pop     = en && !q_empty;
   assign out_empty = !out_valid_ff;
   assign status    = out_status_ff;
   assign hit_x     = out_hit_ff[0];
   assign hit_y     = out_hit_ff[1];
   assign hit_z     = out_hit_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff  <= !q_empty;
         b2_valid_ff  <= b1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[QB-1:0], b2_valid_ff};
         out_valid_ff <= dv_valid_ff[QB];
      end
   end

   // numerators and inside test
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_in[c] = '0;
         for (int k = 0; k < 3; k++) begin
            num_in[c] = num_in[c] + (NUMW'(b1_sb_ff[c][k]) <<< (k * CKW))
                        + (NUMW'(b1_da_ff[c][k]) <<< (k * CKW));
         end
      end
      det_x = IW'(b1_det_ff);
      sn_x  = IW'(b1_sn_ff);
      tn_x  = IW'(b1_tn_ff);
      if (det_x[IW-1]) begin
         det_x = -det_x;
         sn_x  = -sn_x;
         tn_x  = -tn_x;
      end
      inside_in = !sn_x[IW-1] && !tn_x[IW-1] && !(det_x < (sn_x + tn_x));
   end

   // divider setup and one quotient bit per stage
   always_comb begin
      dv_den_in[0] = {b2_babs_ff, 1'b0};
      for (int c = 0; c < 3; c++) begin
         num_abs[c]      = b2_num_ff[c][NUMW-1] ? NUMW'(-b2_num_ff[c]) : NUMW'(b2_num_ff[c]);
         dv_rem_in[0][c] = (RW'(num_abs[c]) << (F + 1)) + RW'(b2_babs_ff);
         dv_q_in[0][c]   = '0;
         dv_neg_in[0][c] = b2_num_ff[c][NUMW-1] ^ b2_bneg_ff;
         dv_cap_in[0][c] = dv_rem_in[0][c] >= (RW'(dv_den_in[0]) << QB);
      end
      for (int j = 1; j <= QB; j++) begin
         dv_den_in[j] = dv_den_ff[j-1];
         for (int c = 0; c < 3; c++) begin
            shifted         = RW'(dv_den_ff[j-1]) << (QB - j);
            dv_neg_in[j][c] = dv_neg_ff[j-1][c];
            dv_cap_in[j][c] = dv_cap_ff[j-1][c];
            dv_q_in[j][c]   = dv_q_ff[j-1][c];
            dv_rem_in[j][c] = dv_rem_ff[j-1][c];
            if (dv_rem_ff[j-1][c] >= shifted) begin
               dv_rem_in[j][c]         = dv_rem_ff[j-1][c] - shifted;
               dv_q_in[j][c][QB - j]   = 1'b1;
            end
         end
      end
   end

   // sign, saturation and final status
   always_comb begin
      if (dv_cls_ff[QB] == lti_pkg::STATUS_OUTSIDE && dv_inside_ff[QB]) begin
         out_status_in = lti_pkg::STATUS_INSIDE;
      end else begin
         out_status_in = dv_cls_ff[QB];
      end
      for (int c = 0; c < 3; c++) begin
         if (dv_cap_ff[QB][c]) begin
            out_hit_in[c] = dv_neg_ff[QB][c] ? lti_pkg::HIT_MIN : lti_pkg::HIT_MAX;
         end else if (dv_neg_ff[QB][c]) begin
            out_hit_in[c] = 32'd0 - {1'b0, dv_q_ff[QB][c]};
         end else begin
            out_hit_in[c] = {1'b0, dv_q_ff[QB][c]};
         end
         if (dv_cls_ff[QB] == lti_pkg::STATUS_DEGENERATE ||
             dv_cls_ff[QB] == lti_pkg::STATUS_PARALLEL) begin
            out_hit_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: partial products of s*b and d*a
         b1_cls_ff <= lti_pkg::status_type'(cls_raw);
         b1_b_ff   <= mi_b;
         b1_det_ff <= mi_det;
         b1_sn_ff  <= mi_sn;
         b1_tn_ff  <= mi_tn;
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               b1_sb_ff[c][k] <= mi_s[c] * chunk(mi_b, k);
               b1_da_ff[c][k] <= mi_d[c] * chunk(mi_a, k);
            end
         end
         // stage 2
         b2_cls_ff    <= b1_cls_ff;
         b2_inside_ff <= inside_in;
         b2_babs_ff   <= b1_b_ff[PW-1] ? PW'(-b1_b_ff) : PW'(b1_b_ff);
         b2_bneg_ff   <= b1_b_ff[PW-1];
         for (int c = 0; c < 3; c++) begin
            b2_num_ff[c] <= num_in[c];
         end
         // divider
         dv_cls_ff[0]    <= b2_cls_ff;
         dv_inside_ff[0] <= b2_inside_ff;
         for (int j = 1; j <= QB; j++) begin
            dv_cls_ff[j]    <= dv_cls_ff[j-1];
            dv_inside_ff[j] <= dv_inside_ff[j-1];
         end
         for (int j = 0; j <= QB; j++) begin
            dv_den_ff[j] <= dv_den_in[j];
            for (int c = 0; c < 3; c++) begin
               dv_rem_ff[j][c] <= dv_rem_in[j][c];
               dv_q_ff[j][c]   <= dv_q_in[j][c];
               dv_neg_ff[j][c] <= dv_neg_in[j][c];
               dv_cap_ff[j][c] <= dv_cap_in[j][c];
            end
         end
         // result register
         out_status_ff <= out_status_in;
         for (int c = 0; c < 3; c++) begin
            out_hit_ff[c] <= out_hit_in[c];
         end
      end
   end

endmodule

/* rtl/line_triangle_intersect.sv */
// Line/triangle intersect: top level with tolerance register and pipeline wiring.
// Throughput: one request per cycle while neither side stalls; the rate is set by the fully
//   pipelined front (5 stages), the 4-entry queue and the back (35 stages incl. the divider).
// Reset (synchronous): pipelines and queue empty, epsilon returns to 1.
module line_triangle_intersect #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   // requests
   input  logic        push,
   output logic        full,
   input  logic [47:0] req_seg_start,
   input  logic [47:0] req_seg_end,
   input  logic [47:0] req_vert0,
   input  logic [47:0] req_vert1,
   input  logic [47:0] req_vert2,
   // results
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_hit_x,
   output logic signed [31:0] rsp_hit_y,
   output logic signed [31:0] rsp_hit_z,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ITEM_W  = lti_pkg::item_width(COORD_WIDTH);
   localparam int Q_DEPTH = 4;

   logic [30:0]       eps_ff;
   logic              front_full;
   logic              mq_push, mq_full, mq_pop, mq_empty;
   logic [ITEM_W-1:0] mq_wdata, mq_rdata;
   logic [31:0]       hit_x, hit_y, hit_z;

   // tolerance register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == lti_pkg::CSR_IDX_EPSILON) ? {1'b0, eps_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 31'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == lti_pkg::CSR_IDX_EPSILON) begin
         eps_ff <= csr_pwdata[30:0];
      end
   end

   assign full = front_full;

   lti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .in_full   (front_full),
      .seg_start (req_seg_start),
      .seg_end   (req_seg_end),
      .vert0     (req_vert0),
      .vert1     (req_vert1),
      .vert2     (req_vert2),
      .epsilon   (eps_ff),
      .q_full    (mq_full),
      .q_push    (mq_push),
      .q_data    (mq_wdata)
   );

   lti_queue #(.WIDTH(ITEM_W), .DEPTH(Q_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (mq_push),
      .wdata (mq_wdata),
      .full  (mq_full),
      .pop   (mq_pop),
      .rdata (mq_rdata),
      .empty (mq_empty)
   );

   lti_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mq_empty),
      .q_pop     (mq_pop),
      .q_data    (mq_rdata),
      .out_pop   (pop),
      .out_empty (empty),
      .status    (rsp_status),
      .hit_x     (hit_x),
      .hit_y     (hit_y),
      .hit_z     (hit_z)
   );

   assign rsp_hit_x = $signed(hit_x);
   assign rsp_hit_y = $signed(hit_y);
   assign rsp_hit_z = $signed(hit_z);

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the line/triangle intersect block.
`timescale 1ns / 1ps

module tb;

   typedef logic signed [255:0] wint_type;
   typedef wint_type vec3_type [3];

   typedef struct {
      lti_pkg::status_type status;
      logic [31:0] hx;
      logic [31:0] hy;
      logic [31:0] hz;
   } hit_rec_type;

   typedef struct {
      logic [47:0] s_pt;
      logic [47:0] e_pt;
      logic [47:0] p0;
      logic [47:0] p1;
      logic [47:0] p2;
   } line_tri_type;

   typedef struct {
      line_tri_type req;
      bit           known;
      hit_rec_type  res;
   } dir_row_type;

   localparam int  WATCHDOG_LIMIT = 5000;
   localparam int  DRAIN_CYCLES   = 45;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [47:0] req_seg_start = '0;
   logic [47:0] req_seg_end = '0;
   logic [47:0] req_vert0 = '0;
   logic [47:0] req_vert1 = '0;
   logic [47:0] req_vert2 = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_status;
   logic signed [31:0] rsp_hit_x;
   logic signed [31:0] rsp_hit_y;
   logic signed [31:0] rsp_hit_z;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   line_triangle_intersect i_dut (.*);

   always #5 clock = ~clock;

   // tolerance as the block should currently hold it
   logic [30:0] tol_model = 31'd1;
   hit_rec_type pending_hits [$];
   int          errors = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          idle_cnt = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          long_hold = 1'b0;
   // typed-in expectation, driven alongside the request it belongs to
   bit          use_known = 1'b0;
   hit_rec_type known_res;

   // ---------------------------------------------------------------- predictor
   function automatic vec3_type unpack_point(input logic [47:0] w);
      vec3_type p;
      for (int i = 0; i < 3; i++) p[i] = wint_type'(signed'(w[16*i +: 16]));
      return p;
   endfunction

   function automatic vec3_type cross3(input vec3_type a, input vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic wint_type dot3(input vec3_type a, input vec3_type b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic wint_type absw(input wint_type x);
      return x < 0 ? -x : x;
   endfunction

   function automatic hit_rec_type intersect_line_tri(input line_tri_type q,
                                                      input logic [30:0] tol);
      hit_rec_type r;
      vec3_type s, e, p0, p1, p2, u, v, n, d, w0, pv, qu;
      wint_type eps, a, b, num, an, ab, quo, val, det, sn, tn;
      logic [31:0] h [3];
      bit neg;
      s = unpack_point(q.s_pt);
      e = unpack_point(q.e_pt);
      p0 = unpack_point(q.p0);
      p1 = unpack_point(q.p1);
      p2 = unpack_point(q.p2);
      r.status = lti_pkg::STATUS_DEGENERATE;
      r.hx = '0;
      r.hy = '0;
      r.hz = '0;
      for (int i = 0; i < 3; i++) begin
         u[i] = p1[i] - p0[i];
         v[i] = p2[i] - p0[i];
         d[i] = e[i] - s[i];
         w0[i] = s[i] - p0[i];
      end
      eps = wint_type'(tol);
      n = cross3(u, v);
      if (dot3(n, n) < eps * eps) return r;
      a = -dot3(n, w0);
      b = dot3(n, d);
      if (b == 0 || absw(b) < eps) begin
         r.status = lti_pkg::STATUS_PARALLEL;
         return r;
      end
      // plane hit, rounded half away from zero, saturated
      for (int i = 0; i < 3; i++) begin
         num = (s[i] * b + d[i] * a) * 65536;
         neg = (num < 0) != (b < 0);
         an = absw(num);
         ab = absw(b);
         quo = (2 * an + ab) / (2 * ab);
         if (quo > 64'sh8000_0000) quo = 64'sh8000_0000;
         if (neg) val = -quo;
         else val = quo > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : quo;
         h[i] = val[31:0];
      end
      r.hx = h[0];
      r.hy = h[1];
      r.hz = h[2];
      // barycentric test by cross-multiplication
      pv = cross3(d, v);
      det = dot3(u, pv);
      sn = dot3(w0, pv);
      qu = cross3(w0, u);
      tn = dot3(d, qu);
      if (det < 0) begin
         det = -det;
         sn = -sn;
         tn = -tn;
      end
      r.status = (sn >= 0 && tn >= 0 && det >= sn + tn) ? lti_pkg::STATUS_INSIDE
                                                         : lti_pkg::STATUS_OUTSIDE;
      return r;
   endfunction

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      hit_rec_type exp_hit;
      if (!reset && push && !full) begin
         if (use_known) pending_hits.push_back(known_res);
         else pending_hits.push_back(intersect_line_tri('{req_seg_start, req_seg_end,
            req_vert0, req_vert1, req_vert2}, tol_model));
      end
      if (!reset && pop && !empty) begin
         if (pending_hits.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            exp_hit = pending_hits.pop_front();
            status_seen[rsp_status]++;
            if (rsp_status !== exp_hit.status) begin
               $error("status: expected %0d, got %0d", exp_hit.status, rsp_status);
               errors++;
            end
            if (rsp_hit_x !== exp_hit.hx) begin
               $error("hit_x: expected %0h, got %0h", exp_hit.hx, rsp_hit_x);
               errors++;
            end
            if (rsp_hit_y !== exp_hit.hy) begin
               $error("hit_y: expected %0h, got %0h", exp_hit.hy, rsp_hit_y);
               errors++;
            end
            if (rsp_hit_z !== exp_hit.hz) begin
               $error("hit_z: expected %0h, got %0h", exp_hit.hz, rsp_hit_z);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("line_triangle_intersect regression: fail");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (long_hold) begin
         long_hold = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- helpers
   function automatic logic [47:0] pk(input int x, input int y, input int z);
      return {z[15:0], y[15:0], x[15:0]};
   endfunction

   function automatic int clamp16(input int x);
      return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
   endfunction

   function automatic int rnd_signed(input int r);
      return $urandom_range(2 * r) - r;
   endfunction

   function automatic line_tri_type random_line_tri();
      line_tri_type q;
      int kind, r, c [3], a [3], b [3], g [3], off [3];
      kind = $urandom_range(9);
      if (kind < 2) begin
         q.s_pt = 48'({$urandom, $urandom});
         q.e_pt = 48'({$urandom, $urandom});
         q.p0 = 48'({$urandom, $urandom});
         q.p1 = 48'({$urandom, $urandom});
         q.p2 = 48'({$urandom, $urandom});
         return q;
      end
      case ($urandom_range(3))
         0: r = 8;
         1: r = 100;
         2: r = 2000;
         default: r = 32767;
      endcase
      for (int i = 0; i < 3; i++) begin
         a[i] = rnd_signed(r);
         b[i] = rnd_signed(r);
         g[i] = (kind == 9) ? b[i] : rnd_signed(r);
         // aim near the centroid, with jitter, from both sides
         c[i] = (a[i] + b[i] + g[i]) / 3 + rnd_signed(r / 4);
         off[i] = rnd_signed(r);
      end
      q.p0 = pk(a[0], a[1], a[2]);
      q.p1 = pk(b[0], b[1], b[2]);
      q.p2 = pk(g[0], g[1], g[2]);
      q.s_pt = pk(clamp16(c[0] + off[0]), clamp16(c[1] + off[1]), clamp16(c[2] + off[2]));
      q.e_pt = pk(clamp16(c[0] - off[0]), clamp16(c[1] - off[1]), clamp16(c[2] - off[2]));
      return q;
   endfunction

   task automatic offer_request(input line_tri_type q);
      req_seg_start <= q.s_pt;
      req_seg_end <= q.e_pt;
      req_vert0 <= q.p0;
      req_vert1 <= q.p1;
      req_vert2 <= q.p2;
      push <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   // each sender cycle idles with the set odds
   task automatic sender_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [30:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * lti_pkg::CSR_IDX_EPSILON);
      csr_pwdata <= {1'b0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tol_model = val;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[30:0] !== val) begin
         $error("epsilon: expected %0d, got %0d", val, csr_prdata[30:0]);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- stimulus
   dir_row_type directed [17] = '{
      // all zero: degenerate
      '{'{48'h0, 48'h0, 48'h0, 48'h0, 48'h0}, 1'b1,
        '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // collinear vertices: degenerate
      '{'{pk(1, 2, 3), pk(4, 5, 6), pk(0, 0, 0), pk(5, 5, 5), pk(-7, -7, -7)},
        1'b1, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // line parallel to the plane
      '{'{pk(0, 0, 5), pk(1, 0, 5), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_PARALLEL, 0, 0, 0}},
      // line lying in the plane
      '{'{pk(1, 1, 0), pk(3, 2, 0), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_PARALLEL, 0, 0, 0}},
      // straight through the interior
      '{'{pk(1, 1, 5), pk(1, 1, -5), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_INSIDE, 32'd65536, 32'd65536, 0}},
      // through a vertex counts as inside
      '{'{pk(0, 0, 5), pk(0, 0, -5), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_INSIDE, 0, 0, 0}},
      // on the hypotenuse
      '{'{pk(5, 5, 5), pk(5, 5, -5), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_INSIDE, 32'd327680, 32'd327680, 0}},
      // plane hit outside
      '{'{pk(20, 20, 5), pk(20, 20, -5), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b1, '{lti_pkg::STATUS_OUTSIDE, 32'd1310720, 32'd1310720, 0}},
      // hit behind the start point
      '{'{pk(1, 1, -5), pk(1, 1, -9), pk(0, 0, 0), pk(10, 0, 0), pk(0, 10, 0)},
        1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // reversed winding
      '{'{pk(2, 3, 7), pk(2, 3, -1), pk(0, 0, 0), pk(0, 10, 0), pk(10, 0, 0)},
        1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // fractional hit point, rounding
      '{'{pk(1, 2, 3), pk(4, -1, -2), pk(0, 0, 0), pk(7, 0, 1), pk(0, 9, -1)},
        1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // grazing line, saturated hit
      '{'{pk(0, 0, 32767), pk(32767, 0, 32766), pk(0, 0, 0), pk(32767, 0, 0),
          pk(0, 32767, 0)}, 1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      '{'{pk(0, 0, 32767), pk(-32768, 0, 32766), pk(0, 0, 0), pk(32767, 0, 0),
          pk(0, 32767, 0)}, 1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      // coordinate extremes
      '{'{pk(-32768, -32768, -32768), pk(32767, 32767, 32767), pk(-32768, 32767, 0),
          pk(32767, -32768, -32768), pk(0, 0, 32767)}, 1'b0,
        '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      '{'{48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_0000,
          48'h0001_8000_FFFF}, 1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      '{'{48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h8000_0000_7FFF, 48'h0000_7FFF_8000,
          48'h7FFF_8000_0000}, 1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}},
      '{'{48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 48'h0F0F_F0F0_0F0F, 48'hF0F0_0F0F_F0F0,
          48'h1234_8765_CDEF}, 1'b0, '{lti_pkg::STATUS_DEGENERATE, 0, 0, 0}}
   };

   initial begin
      line_tri_type q;
      logic [30:0] tol_plan [5];
      int n_items;
      tol_plan = '{31'd0, 31'h7FFF_FFFF, 31'd1000, 31'($urandom_range(1, 100000)), 31'd1};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset tolerance
      foreach (directed[k]) begin
         use_known <= directed[k].known;
         known_res <= directed[k].res;
         offer_request(directed[k].req);
      end
      use_known <= 1'b0;
      wait_drained();

      // random phases, one tolerance each
      for (int ph = 0; ph < 5; ph++) begin
         write_tolerance(tol_plan[ph]);
         if (ph < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 57;
         end else if (ph < 4) begin
            send_idle_pct = 57;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n_items = (ph == 1) ? 150 : 340;
         for (int k = 0; k < n_items; k++) begin
            // stall the result side long enough to back up the input
            if (ph == 0 && k == 100) long_hold = 1'b1;
            // pause the input until every outstanding result is out
            if (ph == 3 && k == 150) wait_drained();
            q = random_line_tri();
            offer_request(q);
            sender_gap();
         end
         wait_drained();
      end

      $display("covered: degenerate %0d, parallel %0d, outside %0d, inside %0d results",
               status_seen[lti_pkg::STATUS_DEGENERATE], status_seen[lti_pkg::STATUS_PARALLEL],
               status_seen[lti_pkg::STATUS_OUTSIDE], status_seen[lti_pkg::STATUS_INSIDE]);
      $display("six tolerance settings incl. 0 and max, with stalls on both sides");
      if (errors == 0) begin
         $display("line_triangle_intersect regression: pass");
      end else begin
         $display("line_triangle_intersect regression: fail");
      end
      $finish;
   end

endmodule
